// File: src/chme_pkg.sv
// Package: constants, types and opcodes for the chained hash map engine.
`default_nettype none
package chme_pkg;
  localparam int unsigned BlockBitsDefault  = 10;
  localparam int unsigned BlockCountDefault = 64;
  localparam int unsigned AddrW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned BktW  = 10;
  localparam logic [15:0] Mult1Reset = 16'd13;
  localparam logic [15:0] Mult2Reset = 16'd241;

  typedef enum logic [2:0] {
    OP_MAKE   = 3'd0,
    OP_FIND   = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  localparam logic REG_MULT1 = 1'b0;
  localparam logic REG_MULT2 = 1'b1;
endpackage
`default_nettype wire

// File: src/chme_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module chme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// File: src/chme_divu.sv
// Iterative 32-by-10 unsigned remainder unit, one bit per cycle.
`default_nettype none
module chme_divu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [9:0]  den_i,
  output logic             done_o,
  output logic [9:0]       rem_o
);
  logic [31:0] num_q, num_d;
  logic [10:0] rem_q, rem_d;
  logic [9:0]  den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [10:0] shifted;

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_o  = 1'b0;
    shifted = {rem_q[9:0], num_q[31]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end
  assign rem_o = rem_d[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

// File: src/chained_hash_map_engine.sv
// Top level: sequencer for chained hash maps over a bump-allocated pool.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation with its map
//   base, bucket count, key and value words. Output channel
//   (out_valid_o/out_ready_i) returns one result per operation: element
//   address, found and overflow.
//   The configuration port writes the two hash multipliers; write it idle.
// Operation:
//   One operation at a time, all map data in one 64K x 32 pool RAM with a
//   registered read; a pool read has an address phase and a data phase.
//   Lookup/insert hashes the key, reduces it modulo the bucket count and walks
//   the chain; insert updates the value on a hit and adds an element and link
//   on a miss. Make map writes the header and clears the buckets, clear clears
//   them, remove scans them. The result is registered once the operation ends
//   and any earlier result has been handed off.
// Reset:
//   Fill block 0, offset 1, multipliers 13 and 241. The pool is not cleared.
// Stall:
//   A result waits in the output register; the next operation is taken as
//   soon as its result is handed off, in that same cycle.
`default_nettype none
module chained_hash_map_engine
  import chme_pkg::*;
#(
  parameter int unsigned BlockBits  = BlockBitsDefault,
  parameter int unsigned BlockCount = BlockCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [15:0] map_base_i,
  input  wire logic [9:0]  bucket_count_i,
  input  wire logic signed [31:0] key_word_zero_i,
  input  wire logic signed [31:0] key_word_one_i,
  input  wire logic signed [31:0] key_word_two_i,
  input  wire logic signed [31:0] value_word_zero_i,
  input  wire logic signed [31:0] value_word_one_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      element_address_o,
  output logic             found_o,
  output logic             overflow_o
);
  localparam int unsigned BSize = 1 << BlockBits;
  localparam int unsigned OffW  = BlockBits + 1;
  localparam int unsigned BlkW  = (BlockCount > 1) ? $clog2(BlockCount) : 1;

  typedef enum logic [17:0] {
    S_IDLE   = 18'd1,
    S_HDR    = 18'd2,
    S_HASH1  = 18'd4,
    S_HASH2  = 18'd8,
    S_DIV    = 18'd16,
    S_SLOT   = 18'd32,
    S_LNXT   = 18'd64,
    S_K0     = 18'd128,
    S_K1     = 18'd256,
    S_K2     = 18'd512,
    S_UPD    = 18'd1024,
    S_INS    = 18'd2048,
    S_FILL   = 18'd4096,
    S_RHEAD  = 18'd8192,
    S_RLINK  = 18'd16384,
    S_RELEM  = 18'd32768,
    S_DONE   = 18'd65536,
    S_WAIT   = 18'd131072
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] mult1_q, mult2_q;
  logic [BlkW-1:0] blk_q, blk_d;
  logic [OffW-1:0] off_q, off_d;

  logic [2:0]  op_q;
  logic [15:0] map_q;
  logic [9:0]  nb_q;
  logic [31:0] k0_q, k1_q, k2_q, v0_q, v1_q;
  logic [31:0] h_q, h_d;
  logic [9:0]  n_q, n_d;
  logic [9:0]  idx_q, idx_d;
  logic [15:0] slot_q, slot_d, link_q, link_d, cand_q, cand_d;
  logic [15:0] head_q, head_d;
  logic [15:0] elem_q, elem_d, lnk_q, lnk_d;
  logic [16:0] steps_q, steps_d;
  logic [2:0]  sub_q, sub_d;
  logic        ph_q, ph_d;
  logic        ovf_q, ovf_d, fnd_q, fnd_d;
  logic [15:0] res_q, res_d;
  logic        ov_q, ov_d;

  logic        we;
  logic [15:0] addr;
  logic [31:0] wdata, rdata;

  logic        div_start, div_done;
  logic [9:0]  div_rem;

  chme_ram #(.Width(WordW), .Depth(1 << AddrW)) u_pool (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
  chme_divu u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(h_q),
    .den_i(n_q), .done_o(div_done), .rem_o(div_rem)
  );

  // bump allocator planning
  typedef struct packed {
    logic            ok;
    logic [BlkW-1:0] blk;
    logic [OffW-1:0] off;
    logic [15:0]     base;
  } plan_t;

  function automatic plan_t plan(logic [BlkW-1:0] b, logic [OffW-1:0] o,
                                 logic [11:0] cnt);
    plan_t       p;
    logic [31:0] bb, oo, base;
    bb = 32'(b);
    oo = 32'(o);
    p  = '0;
    p.ok = 1'b1;
    if (32'(cnt) > BSize) begin
      p.ok = 1'b0;
    end else begin
      if (oo > BSize || (BSize - oo) < 32'(cnt)) begin
        if (bb + 1 >= BlockCount) p.ok = 1'b0;
        bb = bb + 1;
        oo = 0;
      end
      base = (bb << BlockBits) + oo;
      if (base + 32'(cnt) > 32'd65536) p.ok = 1'b0;
      p.blk  = bb[BlkW-1:0];
      p.off  = OffW'(oo + 32'(cnt));
      p.base = base[15:0];
    end
    return p;
  endfunction

  plan_t pm, pe, pl;
  assign pm = plan(blk_q, off_q, 12'(nb_q) + 12'd1);
  assign pe = plan(blk_q, off_q, 12'd5);
  assign pl = plan(pe.blk, pe.off, 12'd2);

  logic [31:0] prod;
  assign prod = (sub_q == 3'd0) ? k1_q * {16'd0, mult1_q} : k2_q * {16'd0, mult2_q};

  // hold output until the transfer completes
  logic idle_block;
  assign idle_block = ov_q && !out_ready_i;

  assign in_ready_o = (state_q == S_IDLE) && !idle_block;
  logic accept;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    blk_d = blk_q; off_d = off_q;
    h_d = h_q; n_d = n_q; idx_d = idx_q;
    slot_d = slot_q; link_d = link_q; cand_d = cand_q; head_d = head_q;
    elem_d = elem_q; lnk_d = lnk_q; steps_d = steps_q;
    sub_d = sub_q; ph_d = ph_q;
    ovf_d = ovf_q; fnd_d = fnd_q;
    res_d = res_q; ov_d = ov_q;
    we = 1'b0; addr = map_q; wdata = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ph_d = 1'b0; sub_d = '0; idx_d = '0; steps_d = '0;
        res_d = '0; fnd_d = 1'b0; ovf_d = 1'b0;
        if (accept) begin
          priority case (operation_i)
            OP_MAKE: state_d = S_FILL;
            OP_FIND, OP_LOOKUP, OP_REMOVE, OP_CLEAR: state_d = S_HDR;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_HDR: begin
        addr = map_q;
        if (!ph_q) ph_d = 1'b1;
        else begin
          ph_d = 1'b0;
          n_d  = rdata[9:0];
          h_d  = k0_q;
          if (rdata[9:0] == 10'd0) state_d = S_DONE;
          else if (op_q == OP_REMOVE) state_d = S_RHEAD;
          else if (op_q == OP_CLEAR) state_d = S_FILL;
          else state_d = S_HASH1;
        end
      end
      S_HASH1: begin
        h_d = h_q + prod;
        if (sub_q == 3'd1) begin
          state_d = S_HASH2;
        end
        sub_d = sub_q + 3'd1;
      end
      S_HASH2: begin
        if (h_q[31]) h_d = 32'd0 - h_q;
        state_d = S_DIV;
        sub_d = '0;
      end
      S_DIV: begin
        if (sub_q == 3'd0) begin
          div_start = 1'b1;
          sub_d = 3'd1;
        end else if (div_done) begin
          slot_d = map_q + 16'd1 + 16'(div_rem);
          sub_d = '0;
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        addr = slot_q;
        if (!ph_q) ph_d = 1'b1;
        else begin
          ph_d = 1'b0;
          link_d = rdata[15:0];
          head_d = rdata[15:0];
          state_d = S_LNXT;
        end
      end
      S_LNXT: begin
        // fetch candidate element pointer of current link
        if (link_q == 16'd0 || steps_q[16]) begin
          state_d = (op_q == OP_FIND) ? S_INS : S_DONE;
          sub_d = '0;
        end else begin
          addr = link_q + 16'd1;
          if (!ph_q) ph_d = 1'b1;
          else begin
            ph_d = 1'b0;
            cand_d = rdata[15:0];
            state_d = S_K0;
          end
        end
      end
      S_K0, S_K1, S_K2: begin
        addr = cand_q + ((state_q == S_K0) ? 16'd0 : (state_q == S_K1) ? 16'd1 : 16'd2);
        if (!ph_q) ph_d = 1'b1;
        else begin
          ph_d = 1'b0;
          if (rdata != ((state_q == S_K0) ? k0_q : (state_q == S_K1) ? k1_q : k2_q)) begin
            state_d = S_WAIT;
          end else if (state_q == S_K0) state_d = S_K1;
          else if (state_q == S_K1) state_d = S_K2;
          else begin
            res_d = cand_q; fnd_d = 1'b1;
            state_d = (op_q == OP_FIND) ? S_UPD : S_DONE;
          end
        end
      end
      S_WAIT: begin
        // advance to the next link
        addr = link_q;
        if (!ph_q) ph_d = 1'b1;
        else begin
          ph_d = 1'b0;
          link_d = rdata[15:0];
          steps_d = steps_q + 17'd1;
          state_d = S_LNXT;
        end
      end
      S_UPD: begin
        we = 1'b1;
        addr = cand_q + ((sub_q == 3'd0) ? 16'd3 : 16'd4);
        wdata = (sub_q == 3'd0) ? v0_q : v1_q;
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd1) state_d = S_DONE;
      end
      S_INS: begin
        if (sub_q == 3'd0) begin
          if (!pe.ok || !pl.ok) begin
            ovf_d = 1'b1;
            state_d = S_DONE;
          end else begin
            elem_d = pe.base; lnk_d = pl.base;
            blk_d = pl.blk; off_d = pl.off;
            res_d = pe.base;
            sub_d = 3'd1;
          end
        end else begin
          we = 1'b1;
          sub_d = sub_q + 3'd1;
          unique case (sub_q)
            3'd1: begin addr = elem_q;         wdata = k0_q; end
            3'd2: begin addr = elem_q + 16'd1; wdata = k1_q; end
            3'd3: begin addr = elem_q + 16'd2; wdata = k2_q; end
            3'd4: begin addr = elem_q + 16'd3; wdata = v0_q; end
            3'd5: begin addr = elem_q + 16'd4; wdata = v1_q; end
            3'd6: begin addr = lnk_q + 16'd1;  wdata = 32'(elem_q); end
            3'd7: begin
              addr = lnk_q; wdata = 32'(head_q);
              sub_d = '0; state_d = S_DONE;
              // slot write follows in done-free step
            end
            default: ;
          endcase
          if (sub_q == 3'd7) begin
            state_d = S_RELEM;
            ph_d = 1'b1;
          end
        end
      end
      S_FILL: begin
        // make map header/bucket clear, or clear buckets
        if (op_q == OP_MAKE && sub_q == 3'd0) begin
          if (!pm.ok) begin
            ovf_d = 1'b1;
            state_d = S_DONE;
          end else begin
            blk_d = pm.blk; off_d = pm.off;
            res_d = pm.base;
            n_d = nb_q;
            sub_d = 3'd1;
            we = 1'b1; addr = pm.base; wdata = 32'(nb_q);
            idx_d = '0;
            if (nb_q == 10'd0) state_d = S_DONE;
          end
        end else begin
          we = 1'b1;
          addr = ((op_q == OP_MAKE) ? res_q : map_q) + 16'd1 + 16'(idx_q);
          wdata = '0;
          idx_d = idx_q + 10'd1;
          sub_d = 3'd1;
          if (idx_q == n_q - 10'd1) state_d = S_DONE;
        end
      end
      S_RHEAD: begin
        addr = map_q + 16'd1 + 16'(idx_q);
        if (!ph_q) ph_d = 1'b1;
        else begin
          ph_d = 1'b0;
          if (rdata[15:0] != 16'd0) begin
            head_d = rdata[15:0];
            state_d = S_RLINK;
          end else if (idx_q == n_q - 10'd1) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + 10'd1;
          end
        end
      end
      S_RLINK: begin
        addr = head_q + ((sub_q == 3'd0) ? 16'd0 : 16'd1);
        if (!ph_q) ph_d = 1'b1;
        else begin
          ph_d = 1'b0;
          if (sub_q == 3'd0) begin
            link_d = rdata[15:0];
            sub_d = 3'd1;
          end else begin
            res_d = rdata[15:0];
            fnd_d = 1'b1;
            slot_d = map_q + 16'd1 + 16'(idx_q);
            lnk_d = link_q;
            state_d = S_RELEM;
          end
        end
      end
      S_RELEM: begin
        // write the bucket head: new link on insert, successor on remove
        we = 1'b1;
        addr = slot_q;
        wdata = (op_q == OP_FIND) ? 32'(lnk_q) : 32'(link_q);
        ph_d = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (state_q == S_DONE) ov_d = 1'b1;
    if (state_q == S_DONE && ov_q && !out_ready_i) begin
      ov_d = 1'b1;
      state_d = S_DONE;
    end
  end

  assign out_valid_o = ov_q;

  logic [15:0] oaddr_q;
  logic        ofnd_q, oovf_q;
  assign element_address_o = oaddr_q;
  assign found_o = ofnd_q;
  assign overflow_o = oovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      blk_q <= '0;
      off_q <= OffW'(1);
      mult1_q <= Mult1Reset;
      mult2_q <= Mult2Reset;
      ov_q <= 1'b0;
      ph_q <= 1'b0;
      sub_q <= '0;
    end else begin
      state_q <= (state_q == S_DONE && idle_block) ? S_DONE : state_d;
      blk_q <= blk_d;
      off_q <= off_d;
      ov_q <= ov_d;
      ph_q <= ph_d;
      sub_q <= sub_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_MULT1) mult1_q <= cfg_data_i;
        if (cfg_index_i == REG_MULT2) mult2_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i; map_q <= map_base_i; nb_q <= bucket_count_i;
      k0_q <= key_word_zero_i; k1_q <= key_word_one_i; k2_q <= key_word_two_i;
      v0_q <= value_word_zero_i; v1_q <= value_word_one_i;
    end
    h_q <= h_d; n_q <= n_d; idx_q <= idx_d;
    slot_q <= slot_d; link_q <= link_d; cand_q <= cand_d; head_q <= head_d;
    elem_q <= elem_d; lnk_q <= lnk_d; steps_q <= steps_d;
    ovf_q <= ovf_d; fnd_q <= fnd_d; res_q <= res_d;
    if (state_q == S_DONE && !idle_block) begin
      oaddr_q <= ovf_q ? 16'd0 : res_q;
      ofnd_q  <= fnd_q;
      oovf_q  <= ovf_q;
    end
  end
endmodule
`default_nettype wire

// File: src/chme_checker.sv
// Port-level checker for the chained hash map engine, bound to the top level.
`default_nettype none
module chme_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] element_address_o,
  input wire logic        found_o,
  input wire logic        overflow_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_address_o))
    else $error("result changed while stalled");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> element_address_o == 16'd0 && !found_o)
    else $error("overflow result not clean");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken without a result");
endmodule
bind chained_hash_map_engine chme_checker u_chme_checker (.*);
`default_nettype wire
